/* rtl/fdrdq_pkg.sv */
// ----------------------------------------------------------------------------
// fdrdq_pkg
// Shared types, constants and helpers of the fixed delay / random drop queue.
// ----------------------------------------------------------------------------
`default_nettype none

package fdrdq_pkg;

    // default sizing
    localparam int QUEUE_DEPTH_DEF = 4096;
    localparam int BURST_SIZE_DEF  = 32;
    localparam int MAX_RESULTS     = 32;

    // payload and register widths
    localparam int TIME_W    = 64;
    localparam int ID_W      = 16;
    localparam int DELAY_W   = 32;
    localparam int THRESH_W  = 31;
    localparam int PRNG_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam logic [THRESH_W-1:0] THRESH_MAX = {THRESH_W{1'b1}};

    // register reset values
    localparam logic                DELAY_MODE_RST = 1'b1;
    localparam logic [DELAY_W-1:0]  DELAY_RST      = '0;
    localparam logic [PRNG_W-1:0]   PRNG_RST       = PRNG_W'(1);

    // input item kinds
    localparam logic KIND_ARRIVAL = 1'b0;
    localparam logic KIND_POLL    = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY_MODE  = 2'd0,
        CFG_DELAY       = 2'd1,
        CFG_THRESHOLD   = 2'd2,
        CFG_PRNG_SEED   = 2'd3
    } t_cfg_index;

    // one xorshift step (13, 17, 5)
    function automatic logic [PRNG_W-1:0] xorshift32(input logic [PRNG_W-1:0] x);
        logic [PRNG_W-1:0] a;
        logic [PRNG_W-1:0] b;
        a = x ^ (x << 13);
        b = a ^ (a >> 17);
        return b ^ (b << 5);
    endfunction

endpackage

`default_nettype wire

/* rtl/fdrdq_ram.sv */
// ----------------------------------------------------------------------------
// fdrdq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module fdrdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/fixed_delay_random_drop_queue_top.sv */
// ----------------------------------------------------------------------------
// fixed_delay_random_drop_queue_top
// Network impairment element: fixed delay ring with pseudo-random drop.
// ----------------------------------------------------------------------------
// Input words (i_in_valid / o_in_stall) are packet arrivals or drain polls.
// Result words (o_out_valid / i_out_stall) carry a descriptor with discard,
// overflow and last marks. Configuration writes (i_cfg_valid / o_cfg_ready)
// are always taken and must only be issued while the block is idle.
// Arrival in drop-only mode, or into a full ring: one result, registered,
// visible the cycle after acceptance. Arrival stored into the ring: no
// result. One arrival is taken per cycle while the output register is free.
// Poll: the ring entry at the read pointer is read from the descriptor RAM
// (registered read data), compared with the poll time, and each released
// entry is held until the next entry is checked, so its last mark is known.
// Results follow one per cycle while the receiver does not stall; a poll
// on an empty ring releases nothing; no input is taken during a poll.
// The RAM read port sets that pace.
// Reset empties the ring (pointers to zero, RAM contents are not cleared)
// and loads the generator with 1. A stall from the receiver holds the
// result register and, through o_in_stall, blocks new input words.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_delay_random_drop_queue_top #(
    parameter int QUEUE_DEPTH = fdrdq_pkg::QUEUE_DEPTH_DEF,
    parameter int BURST_SIZE  = fdrdq_pkg::BURST_SIZE_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // input channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic                             i_kind,
    input  wire logic [fdrdq_pkg::TIME_W-1:0]     i_now_time,
    input  wire logic [fdrdq_pkg::ID_W-1:0]       i_packet_id,
    // output channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic      [fdrdq_pkg::ID_W-1:0]       o_out_packet_id,
    output logic                                  o_discard,
    output logic                                  o_overflow,
    output logic                                  o_last,
    // configuration channel
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [fdrdq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [fdrdq_pkg::CFG_DAT_W-1:0]  i_cfg_data
);

    localparam int PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int POLL_LIMIT = (BURST_SIZE < fdrdq_pkg::MAX_RESULTS) ?
                                BURST_SIZE : fdrdq_pkg::MAX_RESULTS;
    localparam int CNT_W      = $clog2(POLL_LIMIT + 1);
    localparam int ENTRY_W    = fdrdq_pkg::TIME_W + fdrdq_pkg::ID_W;

    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(POLL_LIMIT);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CHECK = 3'b010,
        ST_FLUSH = 3'b100
    } t_state;

    // configuration
    logic                              r_delay_mode;
    logic [fdrdq_pkg::DELAY_W-1:0]     r_delay;
    logic [fdrdq_pkg::THRESH_W-1:0]    r_threshold;

    // control state
    t_state                            r_state, n_state;
    logic [PTR_W-1:0]                  r_wp, n_wp;
    logic [PTR_W-1:0]                  r_rp, n_rp;
    logic [CNT_W-1:0]                  r_cnt, n_cnt;
    logic [fdrdq_pkg::PRNG_W-1:0]      r_prng, n_prng;
    logic [fdrdq_pkg::TIME_W-1:0]      r_now, n_now;

    // held result whose last mark is not yet known
    logic                              r_pend_valid, n_pend_valid;
    logic [fdrdq_pkg::ID_W-1:0]        r_pend_id, n_pend_id;
    logic                              r_pend_disc, n_pend_disc;

    // output register
    logic                              r_out_valid;
    logic [fdrdq_pkg::ID_W-1:0]        r_out_id;
    logic                              r_out_disc;
    logic                              r_out_ovf;
    logic                              r_out_last;

    logic                              out_free;
    logic                              in_accept;
    logic                              emit;
    logic [fdrdq_pkg::ID_W-1:0]        emit_id;
    logic                              emit_disc;
    logic                              emit_ovf;
    logic                              emit_last;

    logic [fdrdq_pkg::PRNG_W-1:0]      draw_word;
    logic                              draw_drop;
    logic [PTR_W-1:0]                  wp_next;
    logic [PTR_W-1:0]                  rp_next;
    logic                              ring_full;
    logic                              ring_empty;
    logic [CNT_W-1:0]                  cnt_inc;

    logic                              ram_we;
    logic                              ram_re;
    logic [PTR_W-1:0]                  ram_raddr;
    logic [ENTRY_W-1:0]                ram_wdata;
    logic [ENTRY_W-1:0]                ram_rdata;
    logic [fdrdq_pkg::TIME_W-1:0]      rd_deadline;
    logic [fdrdq_pkg::ID_W-1:0]        rd_id;
    logic                              rd_due;
    logic                              burst_done;

    fdrdq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) || !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign wp_next    = (r_wp == PTR_LAST) ? '0 : r_wp + PTR_W'(1);
    assign rp_next    = (r_rp == PTR_LAST) ? '0 : r_rp + PTR_W'(1);
    assign ring_full  = (wp_next == r_rp);
    assign ring_empty = (r_rp == r_wp);
    assign cnt_inc    = r_cnt + CNT_W'(1);

    assign draw_word  = fdrdq_pkg::xorshift32(r_prng);
    assign draw_drop  = draw_word[fdrdq_pkg::THRESH_W-1:0] > r_threshold;

    assign ram_wdata   = {i_now_time + fdrdq_pkg::TIME_W'(r_delay), i_packet_id};
    assign rd_deadline = ram_rdata[ENTRY_W-1:fdrdq_pkg::ID_W];
    assign rd_id       = ram_rdata[fdrdq_pkg::ID_W-1:0];
    assign rd_due      = (rd_deadline <= r_now);
    assign burst_done  = (cnt_inc == CNT_LIMIT) || (rp_next == r_wp);

    always_comb begin
        n_state      = r_state;
        n_wp         = r_wp;
        n_rp         = r_rp;
        n_cnt        = r_cnt;
        n_prng       = r_prng;
        n_now        = r_now;
        n_pend_valid = r_pend_valid;
        n_pend_id    = r_pend_id;
        n_pend_disc  = r_pend_disc;
        emit         = 1'b0;
        emit_id      = r_pend_id;
        emit_disc    = r_pend_disc;
        emit_ovf     = 1'b0;
        emit_last    = 1'b1;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = r_rp;

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if (i_kind == fdrdq_pkg::KIND_ARRIVAL) begin
                        if (!r_delay_mode) begin
                            n_prng    = draw_word;
                            emit      = 1'b1;
                            emit_id   = i_packet_id;
                            emit_disc = draw_drop;
                        end else if (ring_full) begin
                            emit      = 1'b1;
                            emit_id   = i_packet_id;
                            emit_disc = 1'b1;
                            emit_ovf  = 1'b1;
                        end else begin
                            ram_we = 1'b1;
                            n_wp   = wp_next;
                        end
                    end else begin
                        n_now = i_now_time;
                        n_cnt = '0;
                        if (!ring_empty) begin
                            ram_re  = 1'b1;
                            n_state = ST_CHECK;
                        end
                    end
                end
            end
            ST_CHECK: begin
                if (!r_pend_valid || out_free) begin
                    if (rd_due) begin
                        // release the held entry; this one is held in its place
                        emit         = r_pend_valid;
                        emit_last    = 1'b0;
                        n_pend_valid = 1'b1;
                        n_pend_id    = rd_id;
                        n_pend_disc  = 1'b0;
                        if (r_threshold != fdrdq_pkg::THRESH_MAX) begin
                            n_prng      = draw_word;
                            n_pend_disc = draw_drop;
                        end
                        n_rp  = rp_next;
                        n_cnt = cnt_inc;
                        if (burst_done) begin
                            n_state = ST_FLUSH;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = rp_next;
                        end
                    end else begin
                        emit         = r_pend_valid;
                        n_pend_valid = 1'b0;
                        n_state      = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    emit         = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_cfg_valid && o_cfg_ready &&
            (fdrdq_pkg::t_cfg_index'(i_cfg_index) == fdrdq_pkg::CFG_PRNG_SEED)) begin
            // a zero seed would lock the generator
            n_prng = (i_cfg_data == '0) ? fdrdq_pkg::PRNG_RST : i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_wp         <= '0;
            r_rp         <= '0;
            r_cnt        <= '0;
            r_prng       <= fdrdq_pkg::PRNG_RST;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_delay_mode <= fdrdq_pkg::DELAY_MODE_RST;
            r_delay      <= fdrdq_pkg::DELAY_RST;
            r_threshold  <= fdrdq_pkg::THRESH_MAX;
        end else begin
            r_state      <= n_state;
            r_wp         <= n_wp;
            r_rp         <= n_rp;
            r_cnt        <= n_cnt;
            r_prng       <= n_prng;
            r_pend_valid <= n_pend_valid;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (fdrdq_pkg::t_cfg_index'(i_cfg_index))
                    fdrdq_pkg::CFG_DELAY_MODE: r_delay_mode <= i_cfg_data[0];
                    fdrdq_pkg::CFG_DELAY:      r_delay      <= i_cfg_data;
                    fdrdq_pkg::CFG_THRESHOLD:
                        r_threshold <= i_cfg_data[fdrdq_pkg::THRESH_W-1:0];
                    fdrdq_pkg::CFG_PRNG_SEED: begin
                        // generator reload goes through n_prng
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_now       <= n_now;
        r_pend_id   <= n_pend_id;
        r_pend_disc <= n_pend_disc;
        if (emit) begin
            r_out_id   <= emit_id;
            r_out_disc <= emit_disc;
            r_out_ovf  <= emit_ovf;
            r_out_last <= emit_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_packet_id = r_out_id;
    assign o_discard       = r_out_disc;
    assign o_overflow      = r_out_ovf;
    assign o_last          = r_out_last;

    // checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_LIMIT)
        else $error("poll result count beyond burst limit");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_valid)
        else $error("held result left behind after poll");

    a_flush_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> r_pend_valid)
        else $error("flush without a held result");

    a_check_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK) |-> (r_rp != r_wp))
        else $error("ring read while empty");

    a_prng_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prng != '0)
        else $error("generator stuck at zero");

endmodule

`default_nettype wire
